// ----- rtl/ais_pkg.sv -----
// ---------------------------------------------------------------------------
// ais_pkg
// Shared constants and types for the ascending integer sorter cell chain.
// ---------------------------------------------------------------------------
package ais_pkg;

    localparam int MAX_LEN = 16;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = $clog2(MAX_LEN + 1);

    // Contents of one cell: an element and its occupancy bit
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } slot_t;

    // Row-wide commands, same for every cell
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

// ----- rtl/ascending_integer_sorter.sv -----
// ---------------------------------------------------------------------------
// ascending_integer_sorter
// Collects a list of signed words and returns it in ascending order.
// ---------------------------------------------------------------------------
// The list is held sorted at all times in a row of MAX_LEN cells: each
// accepted element is written into the first cell larger than it, with every
// later larger cell taking its left neighbor's contents. Input takes one
// element per cycle while collecting. The transfer that carries is_final moves
// the block to output, where the row shifts toward cell 0 by one cell per
// result transfer; no input is taken during output.
// Elements beyond MAX_LEN are dropped and every result of that list is flagged
// overflowed. No clearing pass is needed after reset.
module ascending_integer_sorter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [ais_pkg::DATA_W-1:0] value,
    input  logic                             is_final,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [ais_pkg::DATA_W-1:0] sorted_value,
    output logic                             is_last,
    output logic                             overflowed
);
    import ais_pkg::*;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_DRAIN   = 2'b10
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 overflow_reg;
    logic                 overflow_next;

    cell_ctrl_t           ctrl;
    slot_t                slots [MAX_LEN];
    logic [MAX_LEN-1:0]   gts;
    logic [MAX_LEN-1:0]   slot_valid;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 full;

    assign in_ready  = (state_reg == ST_COLLECT);
    assign out_valid = (state_reg == ST_DRAIN) && slots[0].valid;
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;
    assign full      = (count_reg == COUNT_W'(MAX_LEN));

    assign ctrl.insert = in_xfer && !full;
    assign ctrl.drain  = out_xfer;

    assign sorted_value = slots[0].value;
    assign is_last      = !slots[1].valid;
    assign overflowed   = overflow_reg;

    genvar i;
    generate
        for (i = 0; i < MAX_LEN; i++)
        begin : g_cell
            slot_t left_s;
            logic  left_g;
            slot_t right_s;

            if (i == 0)
            begin : g_first
                assign left_s = '0;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_s = slots[i-1];
                assign left_g = gts[i-1];
            end

            if (i == MAX_LEN - 1)
            begin : g_last
                assign right_s = '0;
            end
            else
            begin : g_inner
                assign right_s = slots[i+1];
            end

            ais_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (value),
                .left_slot  (left_s),
                .left_gt    (left_g),
                .right_slot (right_s),
                .slot       (slots[i]),
                .gt         (gts[i])
            );

            assign slot_valid[i] = slots[i].valid;
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_xfer)
                begin
                    if (full)
                        overflow_next = 1'b1;
                    else
                        count_next = count_reg + COUNT_W'(1);
                    if (is_final)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_xfer && is_last)
                begin
                    state_next    = ST_COLLECT;
                    count_next    = '0;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_COLLECT;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

`ifndef SYNTH
    // The count holds while the row drains, so compare only while collecting
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COLLECT) |-> ($countones(slot_valid) == int'(count_reg)))
        else $error("occupied cells disagree with element count");

    a_final_starts_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_final) |=> out_valid)
        else $error("final element transfer did not start output");

    a_last_ends_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && is_last) |=> (!out_valid && in_ready && count_reg == '0))
        else $error("output did not end after last result");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output active together");
`endif

endmodule

// ----- rtl/ais_cell.sv -----
// ---------------------------------------------------------------------------
// ais_cell
// One sorter cell: holds one element, takes part in insertion and draining.
// ---------------------------------------------------------------------------
module ais_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ais_pkg::cell_ctrl_t              ctrl,
    input  logic signed [ais_pkg::DATA_W-1:0] new_value,
    input  ais_pkg::slot_t                   left_slot,
    input  logic                             left_gt,
    input  ais_pkg::slot_t                   right_slot,
    output ais_pkg::slot_t                   slot,
    output logic                             gt
);
    import ais_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // Empty cells count as larger than anything
    assign gt = !valid_reg || (value_reg > new_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert && gt)
        begin
            if (left_gt)
            begin
                // shift the left neighbor in to open the gap further left
                valid_next = left_slot.valid;
                value_next = left_slot.value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = new_value;
            end
        end
        else if (ctrl.drain)
        begin
            valid_next = right_slot.valid;
            value_next = right_slot.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign slot.valid = valid_reg;
    assign slot.value = value_reg;

endmodule
